FILE: hdl/cesr_pkg.sv
// Package for the compressed-row edge search block.
// Holds the item and result structs, function codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cesr_pkg;

    // Function codes carried in the func field of a request.
    typedef enum logic [1:0] {
        FUNC_WR_ROW   = 2'd0,
        FUNC_WR_EDGE  = 2'd1,
        FUNC_FIND     = 2'd2,
        FUNC_REVERSE  = 2'd3
    } cesr_func_t;

    // Request item.
    typedef struct packed {
        cesr_func_t   func;
        logic [16:0]  vertex_a;
        logic [15:0]  vertex_b;
        logic [19:0]  edge_slot;
        logic [20:0]  row_start_value;
    } cesr_req_t;

    // Result item.
    typedef struct packed {
        logic         found;
        logic [19:0]  edge_position;
    } cesr_rsp_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_ROW,
        ST_WR_EDGE,
        ST_SLOT_RD,
        ST_SLOT_WAIT,
        ST_ROW_LO,
        ST_ROW_HI,
        ST_ROW_WAIT,
        ST_SEARCH,
        ST_PROBE,
        ST_OUT
    } cesr_state_t;

    // Width of a slot bound inside the search (row start offsets).
    localparam int BOUND_W = 21;

endpackage

`default_nettype wire

FILE: hdl/cesr_ram.sv
// Generic single-port RAM with registered read data.
// Used for the row start table and the edge target table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cesr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write or one read per cycle; read data appears the next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/csr_edge_search_reverse_lookup.sv
// Top level of the compressed-row edge search block.
// Depends on cesr_pkg and cesr_ram.
`timescale 1ns / 1ps
`default_nettype none

// The block stores a directed graph in compressed-row form: a row start table
// (MAX_VERTICES+1 entries) and an edge target table (MAX_EDGES entries), each
// in a single-port RAM with registered read. One request is taken at a time;
// req_ready is high only while the sequencer is idle, and a finished result
// waits in the output register so the next request can be taken meanwhile.
// A write of a row start or an edge target is done in its own write state. A
// find reads the row's start and end from the row start table, then runs
// binary-search probes (at most ceil(log2(row length + 1))); each probe is one
// read of the edge target RAM and one compare. A reverse lookup first reads
// the stored edge's target, which names the row to search. Both tables come up
// undefined after reset and must be written before they are searched.
module csr_edge_search_reverse_lookup #(
    parameter int MAX_VERTICES = 65536,
    parameter int MAX_EDGES    = 1048576
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire cesr_pkg::cesr_req_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output cesr_pkg::cesr_rsp_t     rsp
);

    import cesr_pkg::*;

    localparam int AW_R = $clog2(MAX_VERTICES + 1);
    localparam int AW_E = $clog2(MAX_EDGES);
    localparam logic [32:0] MAXV_W = 33'(MAX_VERTICES);
    localparam logic [32:0] MAXE_W = 33'(MAX_EDGES);
    localparam logic [BOUND_W-1:0] ZERO_B = '0;

    // Sequencer and output registers.
    cesr_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    cesr_rsp_t   rsp_reg, rsp_next;

    // Item and search registers.
    cesr_req_t            req_reg, req_next;
    logic [16:0]          v_reg, v_next;
    logic [16:0]          key_reg, key_next;
    logic [BOUND_W-1:0]   lo_reg, lo_next;
    logic [BOUND_W-1:0]   hi_reg, hi_next;
    logic [BOUND_W-1:0]   mid_reg, mid_next;
    logic                 hit_reg, hit_next;
    logic [BOUND_W-1:0]   pos_reg, pos_next;

    // RAM ports.
    logic                 row_we, edge_we;
    logic [17:0]          row_idx;
    logic [BOUND_W-1:0]   edge_idx;
    logic [AW_R+17:0]     row_idx_ext;
    logic [AW_E+BOUND_W-1:0] edge_idx_ext;
    logic [AW_R-1:0]      row_addr;
    logic [AW_E-1:0]      edge_addr;
    logic [20:0]          row_rdata;
    logic [15:0]          edge_rdata;

    // Shared datapath terms.
    logic                 accept;
    logic                 rsp_load;
    logic                 row_ok;
    logic                 wr_row_ok;
    logic                 slot_ok;
    logic                 range_empty;
    logic [BOUND_W:0]     bound_sum;
    logic [BOUND_W-1:0]   mid_calc;
    logic [16:0]          probe_tgt;
    logic                 probe_eq;
    logic                 probe_gt;

    assign accept      = req_valid && req_ready;
    assign req_ready   = (state_reg == ST_IDLE);
    assign rsp_load    = (state_reg == ST_OUT) && (!rsp_valid_reg || rsp_ready);
    assign row_ok      = ({16'b0, v_reg} < MAXV_W);
    assign wr_row_ok   = ({16'b0, req_reg.vertex_a} <= MAXV_W);
    assign slot_ok     = ({13'b0, req_reg.edge_slot} < MAXE_W);
    assign range_empty = !(lo_reg < hi_reg);
    assign bound_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc    = bound_sum[BOUND_W:1];
    assign probe_tgt   = {1'b0, edge_rdata};
    assign probe_eq    = (probe_tgt == key_reg);
    assign probe_gt    = (probe_tgt > key_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_WR_ROW:  state_next = ST_WR_ROW;
                        FUNC_WR_EDGE: state_next = ST_WR_EDGE;
                        FUNC_FIND:    state_next = ST_ROW_LO;
                        default:      state_next = ST_SLOT_RD;
                    endcase
                end
            end
            ST_WR_ROW:    state_next = ST_OUT;
            ST_WR_EDGE:   state_next = ST_OUT;
            ST_SLOT_RD:   state_next = slot_ok ? ST_SLOT_WAIT : ST_OUT;
            ST_SLOT_WAIT: state_next = ST_ROW_LO;
            ST_ROW_LO:    state_next = row_ok ? ST_ROW_HI : ST_OUT;
            ST_ROW_HI:    state_next = ST_ROW_WAIT;
            ST_ROW_WAIT:  state_next = ST_SEARCH;
            ST_SEARCH:    state_next = range_empty ? ST_OUT : ST_PROBE;
            ST_PROBE:     state_next = probe_eq ? ST_OUT : ST_SEARCH;
            ST_OUT:       state_next = rsp_load ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory controls and datapath updates for each state.
    always_comb
    begin
        req_next       = req_reg;
        v_next         = v_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        row_we         = 1'b0;
        edge_we        = 1'b0;
        row_idx        = {1'b0, req_reg.vertex_a};
        edge_idx       = {1'b0, req_reg.edge_slot};

        // The output register empties on a transfer.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    v_next   = req.vertex_a;
                    key_next = {1'b0, req.vertex_b};
                    hit_next = 1'b0;
                    pos_next = ZERO_B;
                end
            end
            ST_WR_ROW:
            begin
                row_we = wr_row_ok;
            end
            ST_WR_EDGE:
            begin
                edge_we = slot_ok;
            end
            ST_SLOT_RD:
            begin
                // Read the target of the given edge; it names the row to search.
            end
            ST_SLOT_WAIT:
            begin
                v_next   = {1'b0, edge_rdata};
                key_next = req_reg.vertex_a;
            end
            ST_ROW_LO:
            begin
                row_idx = {1'b0, v_reg};
            end
            ST_ROW_HI:
            begin
                row_idx = {1'b0, v_reg} + 18'd1;
                lo_next = row_rdata;
            end
            ST_ROW_WAIT:
            begin
                // Clip the row end to the size of the edge table.
                if ({12'b0, row_rdata} > MAXE_W)
                begin
                    hi_next = BOUND_W'(MAX_EDGES);
                end
                else
                begin
                    hi_next = row_rdata;
                end
            end
            ST_SEARCH:
            begin
                edge_idx = mid_calc;
                mid_next = mid_calc;
            end
            ST_PROBE:
            begin
                if (probe_eq)
                begin
                    hit_next = 1'b1;
                    pos_next = mid_reg;
                end
                else if (probe_gt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + BOUND_W'(1);
                end
            end
            ST_OUT:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.found         = hit_reg;
                    rsp_next.edge_position = pos_reg[19:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Fit the vertex and slot indices to the RAM address widths.
    assign row_idx_ext  = {{AW_R{1'b0}}, row_idx};
    assign edge_idx_ext = {{AW_E{1'b0}}, edge_idx};
    assign row_addr     = row_idx_ext[AW_R-1:0];
    assign edge_addr    = edge_idx_ext[AW_E-1:0];

    // Row start table.
    cesr_ram #(
        .WIDTH (21),
        .DEPTH (MAX_VERTICES + 1)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (req_reg.row_start_value),
        .rdata (row_rdata)
    );

    // Edge target table.
    cesr_ram #(
        .WIDTH (16),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .addr  (edge_addr),
        .wdata (req_reg.vertex_b),
        .rdata (edge_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and search registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        v_reg   <= v_next;
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        hit_reg <= hit_next;
        pos_reg <= pos_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A probe only happens inside a non-empty range, at its midpoint.
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("probe slot outside the search range");

    // The upper search bound never exceeds the edge table.
    a_hi_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ({12'b0, hi_reg} <= MAXE_W))
        else $error("search bound beyond the edge table");

    // Write requests always answer not found.
    a_write_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load && (req_reg.func == FUNC_WR_ROW || req_reg.func == FUNC_WR_EDGE)
        |=> !rsp_reg.found && (rsp_reg.edge_position == 20'd0))
        else $error("write request produced a hit");

    // A hit reports the slot that matched in the preceding probe.
    a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) && probe_eq |=> hit_reg && (pos_reg == $past(mid_reg)))
        else $error("hit slot not recorded");

    // A transfer in is always followed by work, never an idle cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE) && !req_ready)
        else $error("sequencer idle after a request transfer");

endmodule

`default_nettype wire

FILE: dv/csr_edge_search_reverse_lookup_tb.sv
// Self-checking testbench for csr_edge_search_reverse_lookup.
// Writes small compressed-row graphs, looks edges up and checks every result.
// Depends on cesr_pkg and the block's RTL.
`timescale 1ns / 1ps

module csr_edge_search_reverse_lookup_tb;

    import cesr_pkg::*;

    localparam int unsigned MAX_VERTICES  = 65536;
    localparam int unsigned MAX_EDGES     = 1048576;
    localparam int unsigned DRAIN_CYCLES  = 80;
    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int unsigned HOLDOFF_LEN   = 300;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    cesr_req_t req_item  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    cesr_rsp_t rsp;

    // Shadow copy of both tables; an entry exists only once it was written.
    logic [20:0] row_tab [int];
    logic [15:0] edge_tab [int];

    cesr_rsp_t   pending_results [$];
    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_gap_pct  = 33;
    int unsigned rsp_gap_pct   = 69;
    int unsigned rsp_stall_left = 0;

    // Layout of the graph written last.
    int unsigned graph_first_vertex = 0;
    int unsigned graph_vertices     = 1;
    int unsigned graph_first_slot   = 0;
    int unsigned graph_edges        = 0;

    csr_edge_search_reverse_lookup #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Binary search of one row; clears all_written if it touches an unwritten entry.
    function automatic logic search_row(input int unsigned v, input int unsigned key,
                                        output logic [19:0] pos, inout bit all_written);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        pos = '0;
        if (v >= MAX_VERTICES)
            return 1'b0;
        if (!row_tab.exists(v) || !row_tab.exists(v + 1))
        begin
            all_written = 1'b0;
            return 1'b0;
        end
        lo = row_tab[v];
        hi = row_tab[v + 1];
        if (hi > MAX_EDGES)
            hi = MAX_EDGES;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (!edge_tab.exists(mid))
            begin
                all_written = 1'b0;
                return 1'b0;
            end
            if (edge_tab[mid] == key)
            begin
                pos = 20'(mid);
                return 1'b1;
            end
            if (edge_tab[mid] > key)
                hi = mid;
            else
                lo = mid + 1;
        end
        return 1'b0;
    endfunction

    // Result the block owes for one request, given the tables as they stand.
    function automatic cesr_rsp_t lookup_result(input cesr_req_t item, output bit all_written);
        cesr_rsp_t   res;
        logic [19:0] pos;
        logic        hit;
        all_written = 1'b1;
        hit = 1'b0;
        pos = '0;
        case (item.func)
            FUNC_FIND:
                hit = search_row(item.vertex_a, item.vertex_b, pos, all_written);
            FUNC_REVERSE:
                if (item.edge_slot < MAX_EDGES)
                begin
                    if (!edge_tab.exists(item.edge_slot))
                        all_written = 1'b0;
                    else
                        hit = search_row(edge_tab[item.edge_slot], item.vertex_a, pos,
                                         all_written);
                end
            default: ;
        endcase
        res.found         = hit;
        res.edge_position = hit ? pos : '0;
        return res;
    endfunction

    // Apply a table write to the shadow copy; out-of-range writes are dropped.
    function automatic void store_write(input cesr_req_t item);
        if (item.func == FUNC_WR_ROW && item.vertex_a <= MAX_VERTICES)
            row_tab[item.vertex_a] = item.row_start_value;
        else if (item.func == FUNC_WR_EDGE && item.edge_slot < MAX_EDGES)
            edge_tab[item.edge_slot] = item.vertex_b;
    endfunction

    // ------------------------------------------------------------------
    // Request builders; fields a function ignores carry random values.
    // ------------------------------------------------------------------

    function automatic cesr_req_t random_req();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return cesr_req_t'(raw[$bits(cesr_req_t)-1:0]);
    endfunction

    function automatic cesr_req_t req_row(input int unsigned va, input int unsigned value);
        cesr_req_t r;
        r = random_req();
        r.func            = FUNC_WR_ROW;
        r.vertex_a        = 17'(va);
        r.row_start_value = 21'(value);
        return r;
    endfunction

    function automatic cesr_req_t req_edge(input int unsigned slot, input int unsigned target);
        cesr_req_t r;
        r = random_req();
        r.func      = FUNC_WR_EDGE;
        r.edge_slot = 20'(slot);
        r.vertex_b  = 16'(target);
        return r;
    endfunction

    function automatic cesr_req_t req_find(input int unsigned va, input int unsigned vb);
        cesr_req_t r;
        r = random_req();
        r.func     = FUNC_FIND;
        r.vertex_a = 17'(va);
        r.vertex_b = 16'(vb);
        return r;
    endfunction

    function automatic cesr_req_t req_reverse(input int unsigned va, input int unsigned slot);
        cesr_req_t r;
        r = random_req();
        r.func      = FUNC_REVERSE;
        r.vertex_a  = 17'(va);
        r.edge_slot = 20'(slot);
        return r;
    endfunction

    // A target stored in the row of v when there is one, else any vertex.
    function automatic int unsigned key_from_row(input int unsigned v);
        int unsigned lo;
        int unsigned hi;
        int unsigned s;
        if (v < MAX_VERTICES && row_tab.exists(v) && row_tab.exists(v + 1))
        begin
            lo = row_tab[v];
            hi = row_tab[v + 1];
            if (hi > MAX_EDGES)
                hi = MAX_EDGES;
            if (lo < hi)
            begin
                s = $urandom_range(hi - 1, lo);
                if (edge_tab.exists(s))
                    return edge_tab[s];
            end
        end
        return $urandom_range(65535);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and record what it should return once it transfers.
    task automatic send_item(input cesr_req_t item);
        bit all_written;
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_item  <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        pending_results.push_back(lookup_result(item, all_written));
        store_write(item);
        items_sent++;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Write a fresh graph: rows of consecutive vertices, sorted targets per row.
    task automatic build_random_graph();
        int unsigned degree [$];
        int unsigned targets [$];
        cesr_req_t   writes [$];
        int unsigned total;
        int unsigned slot;
        int unsigned v;
        int unsigned k;
        degree.delete();
        writes.delete();
        total = 0;
        graph_vertices = $urandom_range(12, 1);
        case ($urandom_range(3))
            0:       graph_first_vertex = MAX_VERTICES - graph_vertices;
            1:       graph_first_vertex = $urandom_range(15);
            default: graph_first_vertex = $urandom_range(MAX_VERTICES - graph_vertices);
        endcase
        for (v = 0; v < graph_vertices; v++)
        begin
            degree.push_back(($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(6));
            total += degree[v];
        end
        graph_edges = total;
        // Now and then the edges end exactly at the top of the edge table.
        if ($urandom_range(3) == 0)
            graph_first_slot = MAX_EDGES - total;
        else
            graph_first_slot = $urandom_range(MAX_EDGES - total);

        slot = graph_first_slot;
        for (v = 0; v <= graph_vertices; v++)
        begin
            writes.push_back(req_row(graph_first_vertex + v, slot));
            if (v < graph_vertices)
                slot += degree[v];
        end

        slot = graph_first_slot;
        for (v = 0; v < graph_vertices; v++)
        begin
            targets.delete();
            for (k = 0; k < degree[v]; k++)
                targets.push_back(($urandom_range(6) == 0) ? $urandom_range(65535) :
                                  graph_first_vertex + $urandom_range(graph_vertices - 1));
            targets.sort();
            foreach (targets[i])
                writes.push_back(req_edge(slot + i, targets[i]));
            slot += degree[v];
        end

        writes.shuffle();
        foreach (writes[i])
            send_item(writes[i]);
    endtask

    // One lookup, mostly aimed at the current graph, with some noise.
    // Lookups that would read an entry never written are drawn again.
    task automatic send_random_lookup();
        cesr_req_t   item;
        cesr_rsp_t   unused_rsp;
        bit          all_written;
        int unsigned pick;
        int unsigned v;
        int unsigned s;
        int unsigned attempt;
        all_written = 1'b0;
        for (attempt = 0; attempt < 16 && !all_written; attempt++)
        begin
            pick = $urandom_range(19);
            v = graph_first_vertex + $urandom_range(graph_vertices - 1);
            s = graph_first_slot + ((graph_edges > 0) ? $urandom_range(graph_edges - 1) : 0);
            if (pick < 7)
                item = req_find(v, key_from_row(v));
            else if (pick < 10)
                item = req_find(v, $urandom_range(65535));
            else if (pick < 15)
                item = req_reverse(edge_tab.exists(s) ? key_from_row(edge_tab[s]) : v, s);
            else if (pick < 17)
                item = req_reverse(v, s);
            else if (pick == 17)
            begin
                // Overwrite an edge or a row bound: unsorted rows and clipped rows.
                if ($urandom_range(1))
                    item = req_edge(s, $urandom_range(65535));
                else
                    item = req_row(v + $urandom_range(1), $urandom_range(1) ?
                                   $urandom_range(2097151, MAX_EDGES) : $urandom);
            end
            else if (pick == 18)
            begin
                // Vertex indexes beyond the vertex table.
                case ($urandom_range(2))
                    0:       item = req_find($urandom_range(131071, MAX_VERTICES),
                                             $urandom_range(65535));
                    1:       item = req_row($urandom_range(131071, MAX_VERTICES + 1), $urandom);
                    default: item = req_reverse($urandom_range(131071, MAX_VERTICES), s);
                endcase
            end
            else
                item = random_req();
            unused_rsp = lookup_result(item, all_written);
        end
        if (!all_written)
            item = req_find(MAX_VERTICES + $urandom_range(65535), $urandom_range(65535));
        send_item(item);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built rows at the top of both tables plus a few empty rows.
    task automatic test_directed();
        localparam int unsigned TOP_V = MAX_VERTICES - 3;
        localparam int unsigned TOP_E = MAX_EDGES - 4;
        send_item(req_row(TOP_V,     TOP_E));
        send_item(req_row(TOP_V + 1, TOP_E + 2));
        send_item(req_row(TOP_V + 2, TOP_E + 3));
        // Last bound lies past the edge table and gets clipped.
        send_item(req_row(MAX_VERTICES, 2097151));
        send_item(req_edge(TOP_E,     0));
        send_item(req_edge(TOP_E + 1, 65535));
        send_item(req_edge(TOP_E + 2, 65535));
        send_item(req_edge(TOP_E + 3, 65534));
        // Row 0 starts above its end, row 1 starts at its end.
        send_item(req_row(0, 5));
        send_item(req_row(1, 0));
        send_item(req_row(2, 0));
        // Writes beyond the vertex table must leave every row alone.
        send_item(req_row(MAX_VERTICES + 1, 0));
        send_item(req_row(131071, 0));

        send_item(req_find(TOP_V, 0));
        send_item(req_find(TOP_V, 65535));
        send_item(req_find(TOP_V, 100));
        send_item(req_find(TOP_V + 2, 65534));
        send_item(req_find(MAX_VERTICES, 0));
        send_item(req_find(131071, 65535));
        send_item(req_find(0, 5));
        send_item(req_find(1, 0));
        send_item(req_reverse(TOP_V + 2, TOP_E + 3));
        send_item(req_reverse(TOP_V + 1, TOP_E + 2));
        send_item(req_reverse(TOP_V, TOP_E));

        // Unsorted row: the search follows its probes, not the contents.
        send_item(req_edge(TOP_E,     65535));
        send_item(req_edge(TOP_E + 1, 0));
        send_item(req_find(TOP_V, 0));
        send_item(req_find(TOP_V, 65535));
    endtask

    task automatic test_random_graphs(input int unsigned item_budget);
        int unsigned start_count;
        start_count = items_sent;
        while (items_sent - start_count < item_budget)
        begin
            build_random_graph();
            repeat ($urandom_range(30, 8))
                send_random_lookup();
        end
    endtask

    // Results are held back while requests keep coming, so the input stalls.
    task automatic test_receiver_holdoff();
        rsp_stall_left = HOLDOFF_LEN;
        repeat (12)
            send_random_lookup();
    endtask

    // The request side goes quiet until everything has drained, then resumes.
    task automatic test_sender_pause();
        repeat (6)
            send_random_lookup();
        wait_for_results();
        repeat (6)
            send_random_lookup();
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checking of each transfer
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : rsp_side
        cesr_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: found=%0b position=%0d",
                         $time, rsp.found, rsp.edge_position);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.found !== want.found)
                begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, rsp.found);
                    error_count++;
                end
                if (rsp.edge_position !== want.edge_position)
                begin
                    $display("%0t: edge_position mismatch: expected %0d, actual %0d",
                             $time, want.edge_position, rsp.edge_position);
                    error_count++;
                end
            end
        end
        if (rsp_stall_left > 0)
        begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_gap_pct);
    end

    // Watchdog: too long without a transfer on either side ends the run.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles a third of the time, receiver two thirds.
        send_gap_pct = 33;
        rsp_gap_pct  = 69;
        test_directed();
        test_random_graphs(300);

        // The other way round.
        send_gap_pct = 69;
        rsp_gap_pct  = 33;
        test_random_graphs(300);
        test_receiver_holdoff();

        // No idling on either side.
        send_gap_pct = 0;
        rsp_gap_pct  = 0;
        test_sender_pause();
        test_random_graphs(300);
        test_receiver_holdoff();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
